/* rtl/direct_mapped_tlb_translate_defines.svh */
// ----------------------------------------------------------------------------
// Direct-mapped TLB assertion macros
// Shared assertion shorthands for the TLB translator checker.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_TLB_TRANSLATE_DEFINES_SVH
`define DIRECT_MAPPED_TLB_TRANSLATE_DEFINES_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define DMTLB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DMTLB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/dmtlb_pkg.sv */
// ----------------------------------------------------------------------------
// Direct-mapped TLB package
// Field widths, defaults, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package dmtlb_pkg;

   localparam int VA_W         = 32;
   localparam int FRAME_W      = 20;
   localparam int SLOT_W       = 4;
   localparam int CYCLES_W     = 16;
   localparam int COUNT_W      = 32;
   localparam int REQ_TDATA_W  = 56;
   localparam int RSP_TDATA_W  = 112;
   localparam int RSP_TUSER_W  = 2;

   localparam int TLB_SLOTS_DEF   = 8;
   localparam int TABLE_PAGES_DEF = 16;
   localparam int OFFSET_BITS_DEF = 12;

   localparam logic [CYCLES_W-1:0] WALK_RESET = 16'd100;
   localparam logic [FRAME_W-1:0]  FRAME_BASE = 20'h00100;
   localparam logic [CYCLES_W-1:0] HIT_CYCLES = 16'd1;

   // Request kinds carried on req_tuser.
   localparam logic ACTION_TRANSLATE = 1'b0;
   localparam logic ACTION_LOAD      = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep;    // write one reset entry of the page table
      logic accept;   // capture the request on the input channel
      logic divide;   // form the page-number reciprocal product
      logic lookup;   // finish the slot index and read both memories
      logic finish;   // resolve hit/miss/fault and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_done;   // the last page table entry is being written
      logic out_free;     // the result register can take a new result
   } sts_type;

endpackage

/* rtl/dmtlb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module dmtlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dmtlb_ctrl.sv */
// ----------------------------------------------------------------------------
// Direct-mapped TLB controller
// Sequences the reset sweep and the four steps of one request.
// ----------------------------------------------------------------------------
module dmtlb_ctrl
   import dmtlb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_EVAL
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

/* rtl/dmtlb_dpath.sv */
// ----------------------------------------------------------------------------
// Direct-mapped TLB datapath
// Slot index arithmetic, TLB and page table memories, counters and result.
// ----------------------------------------------------------------------------
module dmtlb_dpath
   import dmtlb_pkg::*;
#(
   parameter int TLB_SLOTS   = TLB_SLOTS_DEF,
   parameter int TABLE_PAGES = TABLE_PAGES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                req_action,
   input  logic [VA_W-1:0]     req_virtual_address,
   input  logic [SLOT_W-1:0]   req_table_slot,
   input  logic [FRAME_W-1:0]  req_table_frame,
   input  logic                csr_wr_en,
   input  logic [CYCLES_W-1:0] csr_wr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [VA_W-1:0]     rsp_physical_address,
   output logic                rsp_hit,
   output logic                rsp_fault,
   output logic [CYCLES_W-1:0] rsp_charged_cycles,
   output logic [COUNT_W-1:0]  rsp_hit_total,
   output logic [COUNT_W-1:0]  rsp_miss_total
);

   localparam int PAGE_W   = VA_W - OFFSET_BITS;
   localparam int IDX_W    = $clog2(TLB_SLOTS);
   localparam int TP_AW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int K        = PAGE_W + IDX_W;
   localparam int RECIP_W  = PAGE_W + 1;
   localparam int PROD_W   = PAGE_W + RECIP_W;
   localparam int Q_W      = PROD_W - K;
   localparam int REM_W    = PAGE_W + 2;
   localparam int TLB_W    = PAGE_W + FRAME_W;
   localparam int PA_WIDE  = FRAME_W + 16;
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << K) / TLB_SLOTS);
   localparam logic [REM_W-1:0]   SLOTS_REM = REM_W'(TLB_SLOTS);
   localparam logic [TP_AW-1:0]   LAST_PAGE = TP_AW'(TABLE_PAGES - 1);

   // Captured request.
   logic                action_ff;
   logic [VA_W-1:0]     va_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                in_table_ff;
   logic [TP_AW-1:0]    sweep_ff;
   logic [CYCLES_W-1:0] walk_latency_ff;
   logic [TLB_SLOTS-1:0] valid_ff;
   logic [COUNT_W-1:0]  hits_ff;
   logic [COUNT_W-1:0]  misses_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic [VA_W-1:0]     pa_ff;
   logic                hit_ff;
   logic                fault_ff;
   logic [CYCLES_W-1:0] cycles_ff;

   logic [PAGE_W-1:0]   page;
   logic [Q_W-1:0]      quot;
   logic [REM_W-1:0]    rem_raw;
   logic [REM_W-1:0]    rem_fix;
   logic [IDX_W-1:0]    idx_in;

   logic                ft_wr_en;
   logic [TP_AW-1:0]    ft_wr_addr;
   logic [FRAME_W-1:0]  ft_wr_data;
   logic [FRAME_W-1:0]  ft_rd_data;
   logic [TLB_W-1:0]    tlb_rd_data;

   logic                is_hit;
   logic                is_miss;
   logic                is_fault;
   logic [FRAME_W-1:0]  frame_sel;
   logic [PA_WIDE-1:0]  pa_wide;

   assign page = va_ff[VA_W-1:OFFSET_BITS];

   // page mod TLB_SLOTS: the floor reciprocal leaves the quotient at most one
   // short, so one conditional subtract finishes the remainder.
   assign quot    = prod_ff[PROD_W-1:K];
   assign rem_raw = REM_W'(page) - REM_W'(quot * SLOTS_REM);
   assign rem_fix = (rem_raw >= SLOTS_REM) ? (rem_raw - SLOTS_REM) : rem_raw;
   assign idx_in  = rem_fix[IDX_W-1:0];

   // Page table writes come from the reset sweep or from a load request.
   always_comb begin
      if (cmd.sweep) begin
         ft_wr_en   = 1'b1;
         ft_wr_addr = sweep_ff;
         ft_wr_data = FRAME_W'(sweep_ff) + FRAME_BASE;
      end else begin
         ft_wr_en   = cmd.accept && (req_action == ACTION_LOAD)
                      && (32'(req_table_slot) < 32'(TABLE_PAGES));
         ft_wr_addr = TP_AW'(req_table_slot);
         ft_wr_data = req_table_frame;
      end
   end

   dmtlb_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (TABLE_PAGES)
   ) u_frame_table (
      .clock   (clock),
      .wr_en   (ft_wr_en),
      .wr_addr (ft_wr_addr),
      .wr_data (ft_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (TP_AW'(page)),
      .rd_data (ft_rd_data)
   );

   dmtlb_ram #(
      .WIDTH (TLB_W),
      .DEPTH (TLB_SLOTS)
   ) u_tlb (
      .clock   (clock),
      .wr_en   (cmd.finish && is_miss),
      .wr_addr (idx_ff),
      .wr_data ({page, ft_rd_data}),
      .rd_en   (cmd.lookup),
      .rd_addr (idx_in),
      .rd_data (tlb_rd_data)
   );

   assign is_hit   = (action_ff == ACTION_TRANSLATE) && valid_ff[idx_ff]
                     && (tlb_rd_data[TLB_W-1:FRAME_W] == page);
   assign is_miss  = (action_ff == ACTION_TRANSLATE) && !is_hit && in_table_ff;
   assign is_fault = (action_ff == ACTION_TRANSLATE) && !is_hit && !in_table_ff;
   assign frame_sel = is_hit ? tlb_rd_data[FRAME_W-1:0] : ft_rd_data;
   assign pa_wide   = PA_WIDE'({frame_sel, va_ff[OFFSET_BITS-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff        <= '0;
         walk_latency_ff <= WALK_RESET;
         valid_ff        <= '0;
         hits_ff         <= '0;
         misses_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.sweep && (sweep_ff != LAST_PAGE)) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (csr_wr_en) begin
            walk_latency_ff <= csr_wr_data;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (is_hit && (hits_ff != '1)) begin
               hits_ff <= hits_ff + 1'b1;
            end
            if (is_miss) begin
               valid_ff[idx_ff] <= 1'b1;
               if (misses_ff != '1) begin
                  misses_ff <= misses_ff + 1'b1;
               end
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         va_ff     <= req_virtual_address;
      end
      if (cmd.divide) begin
         prod_ff <= PROD_W'(page) * PROD_W'(RECIP);
      end
      if (cmd.lookup) begin
         idx_ff      <= idx_in;
         in_table_ff <= (32'(page) < 32'(TABLE_PAGES));
      end
      if (cmd.finish) begin
         hit_ff    <= is_hit;
         fault_ff  <= is_fault;
         pa_ff     <= (is_hit || is_miss) ? pa_wide[VA_W-1:0] : '0;
         cycles_ff <= is_hit ? HIT_CYCLES : (is_miss ? walk_latency_ff : '0);
      end
   end

   assign sts.sweep_done = (sweep_ff == LAST_PAGE);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = pa_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_fault            = fault_ff;
   assign rsp_charged_cycles   = cycles_ff;
   assign rsp_hit_total        = hits_ff;
   assign rsp_miss_total       = misses_ff;

endmodule

/* rtl/direct_mapped_tlb_translate.sv */
// A request is accepted, then passes through the reciprocal multiply, the memory read
// and the evaluate step before the next request is accepted; a stalled result holds
// the evaluate step until the result register frees.
// Reset: synchronous; the page table is then swept to its reset contents with
// req_tready low. The CSR port is live during the sweep.
// ----------------------------------------------------------------------------
// Direct-mapped TLB translator
// Translates virtual addresses through a direct-mapped TLB backed by a
// single-level page table, and loads page table entries.
// ----------------------------------------------------------------------------
module direct_mapped_tlb_translate
   import dmtlb_pkg::*;
#(
   parameter int TLB_SLOTS   = TLB_SLOTS_DEF,
   parameter int TABLE_PAGES = TABLE_PAGES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] virtual_address, [35:32] table_slot, [55:36] table_frame
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] action
   input  logic                   req_tuser,
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] physical_address, [47:32] charged_cycles, [79:48] hit_total,
   // [111:80] miss_total
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] hit, [1] fault
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // Walk latency register.
   input  logic                   csr_wr_en,
   input  logic [CYCLES_W-1:0]    csr_wr_data
);

   cmd_type             cmd;
   sts_type             sts;

   logic [VA_W-1:0]     physical_address;
   logic                hit;
   logic                fault;
   logic [CYCLES_W-1:0] charged_cycles;
   logic [COUNT_W-1:0]  hit_total;
   logic [COUNT_W-1:0]  miss_total;

   // The controller steps each request through the datapath one at a time.
   // It stays in its sweep state after reset until the page table holds
   // its reset contents.
   dmtlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath owns the data registers and both memories. The result register
   // separates the two channels, so a waiting result never blocks the next
   // request from being accepted.
   dmtlb_dpath #(
      .TLB_SLOTS   (TLB_SLOTS),
      .TABLE_PAGES (TABLE_PAGES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_action           (req_tuser),
      .req_virtual_address  (req_tdata[31:0]),
      .req_table_slot       (req_tdata[35:32]),
      .req_table_frame      (req_tdata[55:36]),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_ready            (rsp_tready),
      .rsp_valid            (rsp_tvalid),
      .rsp_physical_address (physical_address),
      .rsp_hit              (hit),
      .rsp_fault            (fault),
      .rsp_charged_cycles   (charged_cycles),
      .rsp_hit_total        (hit_total),
      .rsp_miss_total       (miss_total)
   );

   // Pack the result fields, first field in the lowest bits.
   assign rsp_tdata = {miss_total, hit_total, charged_cycles, physical_address};
   assign rsp_tuser = {fault, hit};

endmodule

/* rtl/dmtlb_checker.sv */
// ----------------------------------------------------------------------------
// Direct-mapped TLB port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "direct_mapped_tlb_translate_defines.svh"

module dmtlb_checker
   import dmtlb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // A stalled result keeps its contents.
   `DMTLB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Requests are worked one at a time, so an accept closes the input next cycle.
   `DMTLB_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "request accepted while busy")

   // A hit charges HIT_CYCLES and has already been counted.
   `DMTLB_ASSERT(a_hit_counted, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[47:32] == 16'd1 && rsp_tdata[79:48] != 32'd0, "hit result inconsistent")

   // Reset leaves no result pending.
   `DMTLB_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind direct_mapped_tlb_translate dmtlb_checker u_dmtlb_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direct-mapped TLB translator testbench
// Streams translate and page-table load requests into the translator, predicts
// every response with a cycle-free model of the TLB and its page table, and
// compares each response field by field while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import dmtlb_pkg::*;

   // One response as the translator reports it.
   typedef struct packed {
      logic [VA_W-1:0]     pa;
      logic                hit;
      logic                fault;
      logic [CYCLES_W-1:0] cycles;
      logic [COUNT_W-1:0]  hit_total;
      logic [COUNT_W-1:0]  miss_total;
   } translation_type;

   // One directed request. Rows with spelled_out set carry their response
   // inline; the rest are checked against the predictor.
   typedef struct packed {
      logic                action;
      logic [VA_W-1:0]     va;
      logic [SLOT_W-1:0]   slot;
      logic [FRAME_W-1:0]  frame;
      logic                spelled_out;
      translation_type     want;
   } directed_row_type;

   // Receiver behaviors, picked at random whenever drain_phase wraps.
   typedef enum logic [1:0] {
      DRAIN_FREELY,
      DRAIN_SPOTTY,
      DRAIN_BURSTY
   } drain_mode_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_REQUESTS = 100;
   localparam int DIRECTED_ROWS  = 16;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = ACTION_TRANSLATE;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en   = 1'b0;
   logic [CYCLES_W-1:0]    csr_wr_data = '0;

   direct_mapped_tlb_translate dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns period: 2 ns high, 2 ns low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: the TLB slots, the page table, the two saturating
   // counters and the walk latency register.
   // ------------------------------------------------------------------------
   logic                tlb_valid   [TLB_SLOTS_DEF];
   logic [FRAME_W-1:0]  tlb_page    [TLB_SLOTS_DEF];
   logic [FRAME_W-1:0]  tlb_frame   [TLB_SLOTS_DEF];
   logic [FRAME_W-1:0]  page_frames [TABLE_PAGES_DEF];
   logic [COUNT_W-1:0]  hit_count;
   logic [COUNT_W-1:0]  miss_count;
   logic [CYCLES_W-1:0] walk_cycles;

   // Responses still owed by the translator, oldest first.
   translation_type awaited_translations[$];
   int              mismatch_count = 0;

   // Sender burst bookkeeping: requests left in the current burst.
   int burst_left = 0;

   // Applies one request to the predictor state and returns the response it
   // must produce. The page number is the address above the 12 offset bits,
   // and the slot is that page number modulo the slot count.
   function automatic translation_type predict_translation(
         input logic action,
         input logic [VA_W-1:0] va,
         input logic [SLOT_W-1:0] slot,
         input logic [FRAME_W-1:0] frame);
      translation_type    r;
      logic [FRAME_W-1:0] page;
      int                 idx;
      r    = '0;
      page = va[VA_W-1:OFFSET_BITS_DEF];
      idx  = page % TLB_SLOTS_DEF;
      if (action == ACTION_LOAD) begin
         // Loads only touch the page table; cached translations go stale.
         if (slot < TABLE_PAGES_DEF) page_frames[slot] = frame;
      end else if (tlb_valid[idx] && tlb_page[idx] == page) begin
         r.hit    = 1'b1;
         r.cycles = HIT_CYCLES;
         r.pa     = 32'({tlb_frame[idx], va[OFFSET_BITS_DEF-1:0]});
         if (hit_count != '1) hit_count = hit_count + 1;
      end else if (page >= TABLE_PAGES_DEF) begin
         // Off the end of the page table: nothing is filled or counted.
         r.fault = 1'b1;
      end else begin
         tlb_valid[idx] = 1'b1;
         tlb_page[idx]  = page;
         tlb_frame[idx] = page_frames[page];
         r.cycles       = walk_cycles;
         r.pa           = 32'({page_frames[page], va[OFFSET_BITS_DEF-1:0]});
         if (miss_count != '1) miss_count = miss_count + 1;
      end
      r.hit_total  = hit_count;
      r.miss_total = miss_count;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. The sender works in bursts and drops req_tvalid between
   // them. One burst in five is long, which gives stretches where the request
   // channel never idles.
   // ------------------------------------------------------------------------
   task automatic send_request(input logic action, input logic [VA_W-1:0] va,
                               input logic [SLOT_W-1:0] slot,
                               input logic [FRAME_W-1:0] frame,
                               input logic spelled_out, input translation_type want);
      translation_type predicted;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {frame, slot, va};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // Accepted at this edge: the predictor advances in request order.
      predicted = predict_translation(action, va, slot, frame);
      awaited_translations.push_back(spelled_out ? want : predicted);
   endtask

   // Lowers req_tvalid and holds the sender off until every owed response
   // has arrived.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (awaited_translations.size() != 0);
   endtask

   // The translator is idle once nothing is owed: every request gives
   // exactly one response.
   task automatic write_walk_latency(input logic [CYCLES_W-1:0] value);
      wait_for_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      walk_cycles = value;
   endtask

   // Random request mix. Most translations stay inside the page table so
   // that slots fill, hit and get evicted; the rest fault or load the table.
   task automatic send_random_request();
      int                 pick;
      logic [VA_W-1:0]    va;
      logic [FRAME_W-1:0] frame;
      logic               action;
      pick   = $urandom_range(0, 99);
      va     = $urandom;
      frame  = 20'($urandom);
      action = ACTION_TRANSLATE;
      if (pick < 15) begin
         action = ACTION_LOAD;
         case ($urandom_range(0, 5))
            0:       frame = '0;
            1:       frame = '1;
            default: ;
         endcase
      end else if (pick < 85) begin
         va[VA_W-1:OFFSET_BITS_DEF+4] = '0;
      end else if (pick < 93) begin
         va[VA_W-1:OFFSET_BITS_DEF+8]             = '0;
         va[OFFSET_BITS_DEF+7:OFFSET_BITS_DEF]    = 8'($urandom_range(16, 255));
      end
      send_request(action, va, SLOT_W'($urandom), frame, 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Directed requests. Walk latency is at its reset value of 100 here.
   // ------------------------------------------------------------------------
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // First translation after reset walks page 0 to its reset frame.
      '{ACTION_TRANSLATE, 32'h0000_0000, 4'h0, 20'h00000, 1'b1,
        '{32'h0010_0000, 1'b0, 1'b0, WALK_RESET, 32'd0, 32'd1}},
      // Same page, highest offset: a hit.
      '{ACTION_TRANSLATE, 32'h0000_0FFF, 4'h0, 20'h00000, 1'b1,
        '{32'h0010_0FFF, 1'b1, 1'b0, HIT_CYCLES, 32'd1, 32'd1}},
      // Highest address faults; unused fields all ones.
      '{ACTION_TRANSLATE, 32'hFFFF_FFFF, 4'hF, 20'hFFFFF, 1'b1,
        '{32'h0, 1'b0, 1'b1, 16'd0, 32'd1, 32'd1}},
      // First page past the end of the table faults.
      '{ACTION_TRANSLATE, 32'h0001_0000, 4'h0, 20'h00000, 1'b1,
        '{32'h0, 1'b0, 1'b1, 16'd0, 32'd1, 32'd1}},
      // Last page in the table walks.
      '{ACTION_TRANSLATE, 32'h0000_F123, 4'h0, 20'h00000, 1'b1,
        '{32'h0010_F123, 1'b0, 1'b0, WALK_RESET, 32'd1, 32'd2}},
      // Load the last table entry with the largest frame.
      '{ACTION_LOAD, 32'hFFFF_FFFF, 4'hF, 20'hFFFFF, 1'b1,
        '{32'h0, 1'b0, 1'b0, 16'd0, 32'd1, 32'd2}},
      // Stale entry: the cached frame for page 15 is still used.
      '{ACTION_TRANSLATE, 32'h0000_F000, 4'h0, 20'h00000, 1'b0, '0},
      // Page 7 shares a slot with page 15 and evicts it.
      '{ACTION_TRANSLATE, 32'h0000_7000, 4'h0, 20'h00000, 1'b0, '0},
      // Page 15 walks again and picks up the largest frame.
      '{ACTION_TRANSLATE, 32'h0000_F456, 4'h0, 20'h00000, 1'b0, '0},
      // Frame zero into entry 0.
      '{ACTION_LOAD, 32'h0000_0000, 4'h0, 20'h00000, 1'b0, '0},
      // Page 8 evicts page 0 from their shared slot.
      '{ACTION_TRANSLATE, 32'h0000_8ABC, 4'h0, 20'h00000, 1'b0, '0},
      // Page 0 walks to frame zero.
      '{ACTION_TRANSLATE, 32'h0000_0ABC, 4'h0, 20'h00000, 1'b0, '0},
      // Page 8 walks again.
      '{ACTION_TRANSLATE, 32'h0000_8ABC, 4'h0, 20'h00000, 1'b0, '0},
      // Reload entry 8; the cached page 8 goes stale.
      '{ACTION_LOAD, 32'h5555_5555, 4'h8, 20'h5A5A5, 1'b0, '0},
      '{ACTION_TRANSLATE, 32'h0000_8FFF, 4'hA, 20'hA5A5A, 1'b0, '0},
      // Far out of the table.
      '{ACTION_TRANSLATE, 32'h0FFF_F000, 4'h0, 20'h00000, 1'b0, '0}
   };

   // Stimulus: reset, the directed rows, then random phases over a range of
   // walk latencies including both extremes and zero.
   initial begin
      logic [CYCLES_W-1:0] phase_latency [4];
      phase_latency = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 65534))};
      for (int i = 0; i < TLB_SLOTS_DEF; i++) begin
         tlb_valid[i] = 1'b0;
         tlb_page[i]  = '0;
         tlb_frame[i] = '0;
      end
      for (int i = 0; i < TABLE_PAGES_DEF; i++) page_frames[i] = FRAME_BASE + FRAME_W'(i);
      hit_count   = '0;
      miss_count  = '0;
      walk_cycles = WALK_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].action, directed_rows[i].va, directed_rows[i].slot,
                      directed_rows[i].frame, directed_rows[i].spelled_out,
                      directed_rows[i].want);

      foreach (phase_latency[p]) begin
         write_walk_latency(phase_latency[p]);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // Once, in the middle of the third phase, the sender stops until the translator drains.
            if (p == 2 && n == PHASE_REQUESTS / 2) wait_for_responses();
            send_random_request();
         end
      end

      wait_for_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_translations.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: rsp_tready follows a mode picked at random whenever drain_phase
   // wraps - always ready, ready at random three times in four, or a fixed
   // pattern set by the low bits of drain_phase.
   // ------------------------------------------------------------------------
   drain_mode_type drain_mode = DRAIN_FREELY;
   logic [5:0]     drain_phase = '0;

   always @(posedge clock) begin
      drain_phase <= drain_phase + 6'd1;
      if (drain_phase == '0) drain_mode <= drain_mode_type'($urandom_range(0, 2));
      case (drain_mode)
         DRAIN_FREELY: rsp_tready <= 1'b1;
         DRAIN_SPOTTY: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:      rsp_tready <= (drain_phase[3:0] < 4'd5);
      endcase
   end

   // ------------------------------------------------------------------------
   // Response checker and watchdog. Each accepted response is matched
   // against the oldest owed one; the run ends if the idle counter, cleared
   // whenever a request or response is accepted, reaches WATCHDOG_LIMIT.
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   int              idle_cycles = 0;
   translation_type owed;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end else if (rsp_tvalid && rsp_tready) begin
            if (awaited_translations.size() == 0) begin
               $error("response with no request outstanding: tdata 0x%0h", rsp_tdata);
               mismatch_count++;
            end else begin
               owed = awaited_translations.pop_front();
               check_field("physical_address", owed.pa, rsp_tdata[31:0]);
               check_field("hit", 32'(owed.hit), 32'(rsp_tuser[0]));
               check_field("fault", 32'(owed.fault), 32'(rsp_tuser[1]));
               check_field("charged_cycles", 32'(owed.cycles), 32'(rsp_tdata[47:32]));
               check_field("hit_total", owed.hit_total, rsp_tdata[79:48]);
               check_field("miss_total", owed.miss_total, rsp_tdata[111:80]);
            end
         end
      end
   end

endmodule

/* direct_mapped_tlb_translate.f */
+incdir+rtl
rtl/dmtlb_pkg.sv
rtl/dmtlb_ram.sv
rtl/dmtlb_ctrl.sv
rtl/dmtlb_dpath.sv
rtl/direct_mapped_tlb_translate.sv
rtl/dmtlb_checker.sv
dv/tb.sv
